FILE: hdl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer: item layouts, the
// operation codes and the memory control group.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int MODE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 11;

    localparam logic [BYTE_W-1:0] NULL_BYTE = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_STORE       = 3'd0,
        MODE_CONSUME     = 3'd1,
        MODE_CONSUME_ALL = 3'd2,
        MODE_REMOVE_NEW  = 3'd3,
        MODE_PEEK        = 3'd4
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BYTE_W-1:0]  data_byte;
        logic               chunk_last;
        logic               null_terminate;
        logic [COUNT_W-1:0] count;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] amount;
        logic               ok;
        logic [BYTE_W-1:0]  peek_byte;
        logic [COUNT_W-1:0] fill_level;
        logic               is_empty;
    } t_out_item;

    // Result fields known at acceptance; the peek byte follows from memory.
    typedef struct packed {
        logic [COUNT_W-1:0] amount;
        logic               ok;
        logic               peek_ok;
        logic [COUNT_W-1:0] fill_level;
        logic               is_empty;
    } t_res_info;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

FILE: hdl/brb_mem.sv
// ----------------------------------------------------------------------------
// brb_mem
// Byte store: one write enable and one read enable on a single shared address, registered read data.
// ----------------------------------------------------------------------------
module brb_mem #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF,
    parameter int PW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  brb_pkg::t_mem_ctl         i_ctl,
    input  logic [PW-1:0]             i_addr,
    input  logic [brb_pkg::BYTE_W-1:0] i_wdata,
    output logic [brb_pkg::BYTE_W-1:0] o_rdata
);

    logic [brb_pkg::BYTE_W-1:0] r_store [DEPTH];
    logic [brb_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_store[i_addr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_store[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Pointer and fill keeping: decodes one item, drives the memory access and
// works out the result fields.
// ----------------------------------------------------------------------------
module brb_ctrl #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF,
    parameter int PW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  brb_pkg::t_in_item          i_item,
    input  logic                       i_overwrite,
    output brb_pkg::t_mem_ctl          o_mem_ctl,
    output logic [PW-1:0]              o_mem_addr,
    output logic [brb_pkg::BYTE_W-1:0] o_mem_wdata,
    output brb_pkg::t_res_info         o_res
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int AW = PW + 1;
    localparam int XW = (FW > brb_pkg::COUNT_W) ? FW : brb_pkg::COUNT_W;

    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [FW-1:0] r_fill, n_fill;

    logic [XW-1:0] cnt_x, fill_x;
    logic [FW-1:0] cnt_f, take_n;
    logic          full, fills, store_ok;

    function automatic logic [PW-1:0] wrap(input logic [AW-1:0] s);
        logic [AW-1:0] t;
        t = (s >= AW'(DEPTH)) ? s - AW'(DEPTH) : s;
        return t[PW-1:0];
    endfunction

    function automatic logic [brb_pkg::COUNT_W-1:0] to_out(input logic [FW-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        return t[brb_pkg::COUNT_W-1:0];
    endfunction

    always_comb begin
        cnt_x    = XW'(i_item.count);
        fill_x   = XW'(r_fill);
        cnt_f    = FW'(i_item.count);
        full     = (r_fill == FW'(DEPTH));
        fills    = !full && (r_fill == FW'(DEPTH - 1));
        store_ok = !full || i_overwrite;
        take_n   = (cnt_x > fill_x) ? r_fill : cnt_f;
    end

    always_comb begin
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_fill       = r_fill;
        o_mem_ctl    = '0;
        o_mem_addr   = r_wp;
        o_mem_wdata  = i_item.data_byte;
        o_res.amount = '0;
        o_res.ok     = 1'b0;
        o_res.peek_ok = 1'b0;
        unique case (i_item.mode)
            brb_pkg::MODE_STORE: begin
                if (store_ok) begin
                    o_mem_ctl.we = i_take;
                    if (i_item.null_terminate &&
                        (i_item.chunk_last || (!i_overwrite && fills))) begin
                        o_mem_wdata = brb_pkg::NULL_BYTE;
                    end
                    n_wp = wrap(AW'(r_wp) + AW'(1));
                    if (full) begin
                        n_rp = n_wp;
                    end else begin
                        n_fill = r_fill + FW'(1);
                    end
                    o_res.amount = brb_pkg::COUNT_W'(1);
                    o_res.ok     = 1'b1;
                end
            end
            brb_pkg::MODE_CONSUME: begin
                n_rp         = wrap(AW'(r_rp) + AW'(take_n));
                n_fill       = r_fill - take_n;
                o_res.amount = to_out(take_n);
                o_res.ok     = 1'b1;
            end
            brb_pkg::MODE_CONSUME_ALL: begin
                n_rp         = r_wp;
                n_fill       = '0;
                o_res.amount = to_out(r_fill);
                o_res.ok     = 1'b1;
            end
            brb_pkg::MODE_REMOVE_NEW: begin
                if (i_item.count != '0 && cnt_x <= fill_x) begin
                    n_wp         = wrap(AW'(r_wp) + AW'(DEPTH) - AW'(cnt_f));
                    n_fill       = r_fill - cnt_f;
                    o_res.amount = i_item.count;
                    o_res.ok     = 1'b1;
                end
            end
            brb_pkg::MODE_PEEK: begin
                if (cnt_x < fill_x) begin
                    o_mem_ctl.re  = i_take;
                    o_mem_addr    = wrap(AW'(r_rp) + AW'(cnt_f));
                    o_res.amount  = to_out(r_fill - cnt_f);
                    o_res.ok      = 1'b1;
                    o_res.peek_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_res.fill_level = to_out(n_fill);
        o_res.is_empty   = (n_fill == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else if (i_take) begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond depth");

    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_fill == '0) || (r_fill == FW'(DEPTH))) == (r_wp == r_rp))
        else $error("pointers disagree with fill count");

    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_item.mode == brb_pkg::MODE_STORE && !full)
        |=> (r_fill == $past(r_fill) + FW'(1)))
        else $error("store into non-full buffer did not grow fill");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.we && o_mem_ctl.re))
        else $error("read and write issued together");

endmodule

FILE: hdl/byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte FIFO with optional overwrite of the oldest byte, bulk
// consume, removal of the newest bytes and peek at an offset.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ---------------------
//  in        sink       i_in_valid / o_in_ready      i_in_item  (t_in_item)
//  out       source     o_out_valid / i_out_ready    o_out_item (t_out_item)
//  cfg       sink       i_cfg_we (no wait)           i_cfg_wdata (overwrite)
//
//  One item is accepted per cycle while the result register is free or is
//  being emptied in the same cycle; its result shows in the cycle after.
//  Every item does at most one access to the byte store: a store writes it,
//  a peek reads it, and the registered read data lands in the same cycle as
//  the result register, so no forwarding is needed.
//  Reset clears the pointers, the fill count and the overwrite register; the
//  byte store keeps whatever it held and needs no clearing pass.
//  A stalled result holds, and the input stalls until it is taken.
//
module byte_ring_buffer #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  brb_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output brb_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    localparam int PW = $clog2(DEPTH);

    logic                       r_overwrite;
    logic                       r_out_valid;
    brb_pkg::t_res_info         r_res;

    logic                       take;
    brb_pkg::t_res_info         res_next;
    brb_pkg::t_mem_ctl          mem_ctl;
    logic [PW-1:0]              mem_addr;
    logic [brb_pkg::BYTE_W-1:0] mem_wdata;
    logic [brb_pkg::BYTE_W-1:0] mem_rdata;

    // accept when the result slot is free or drains this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    brb_ctrl #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (i_in_item),
        .i_overwrite (r_overwrite),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .o_res       (res_next)
    );

    brb_mem #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // overwrite register: the user must write it only while idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overwrite <= 1'b0;
        end else if (i_cfg_we) begin
            r_overwrite <= i_cfg_wdata;
        end
    end

    // result valid flag: set on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res_next;
        end
    end

    // the store's read register holds its data until the next peek, so the
    // byte stays put for as long as the result waits
    always_comb begin
        o_out_item.amount     = r_res.amount;
        o_out_item.ok         = r_res.ok;
        o_out_item.peek_byte  = r_res.peek_ok ? mem_rdata : brb_pkg::NULL_BYTE;
        o_out_item.fill_level = r_res.fill_level;
        o_out_item.is_empty   = r_res.is_empty;
    end

    assign o_out_valid = r_out_valid;

endmodule
